[rtl/mhp_pkg.sv]
// mac header parser package: phase type, frame control constants, item structs
// and the address length helper; used by the core and the top level
// no dependencies
`default_nettype none

package mhp_pkg;

    typedef enum logic {
        PH_IDLE,
        PH_HDR
    } t_phase;

    localparam logic [2:0]  TYPE_ACK    = 3'd2;
    localparam logic [15:0] PAN_NONE    = 16'hFFFF;
    localparam logic [1:0]  MODE_NONE   = 2'd0;
    localparam logic [1:0]  MODE_SHORT  = 2'd2;
    localparam logic [1:0]  MODE_LONG   = 2'd3;

    // frame control bit positions
    localparam int FC_ACK_REQ_BIT  = 5;
    localparam int FC_INTRA_BIT    = 6;
    localparam int FC_DST_MODE_LSB = 10;
    localparam int FC_SRC_MODE_LSB = 14;

    localparam logic [4:0] CNT_FC_HI = 5'd1;
    localparam logic [4:0] CNT_SEQ   = 5'd2;
    localparam logic [4:0] HDR_FIXED = 5'd3;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
        logic       awaiting_ack;
        logic [7:0] last_tx_seq;
    } t_rx_item;

    typedef struct packed {
        logic [2:0]  frame_type;
        logic        ack_mismatch;
        logic [7:0]  seq_num;
        logic        ack_request;
        logic [1:0]  dst_mode;
        logic [15:0] dst_pan;
        logic [63:0] dst_addr;
        logic [1:0]  src_mode;
        logic [15:0] src_pan;
        logic [63:0] src_addr;
        logic [4:0]  header_len;
    } t_hdr_item;

    // bytes of address carried for an addressing mode
    function automatic logic [4:0] addr_len(input logic [1:0] mode);
        logic [4:0] len;
        case (mode)
            MODE_LONG:  len = 5'd8;
            MODE_SHORT: len = 5'd2;
            default:    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

[rtl/mhp_stream_if.sv]
// valid/ready stream interface carrying one item of type T
// uses no other file; T is a struct from mhp_pkg at the instances
`default_nettype none

interface mhp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/mhp_hdr_core.sv]
// header field assembly: phase, byte count and field registers, one byte per step
// depends on mhp_pkg
`default_nettype none

module mhp_hdr_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire mhp_pkg::t_rx_item  i_item,
    output logic                    o_done,
    output mhp_pkg::t_hdr_item      o_result
);

    mhp_pkg::t_phase r_phase, n_phase;
    logic [4:0]  r_cnt, n_cnt;
    logic [15:0] r_fc, n_fc;
    logic [7:0]  r_seq, n_seq;
    logic [15:0] r_dst_pan, n_dst_pan;
    logic [15:0] r_src_pan, n_src_pan;
    logic [63:0] r_dst_addr, n_dst_addr;
    logic [63:0] r_src_addr, n_src_addr;
    logic        r_ack_wait, n_ack_wait;
    logic [7:0]  r_exp_seq, n_exp_seq;

    logic [1:0] dmode, smode;
    logic       intra;
    logic [4:0] dpl, dal, spl, sal, total;
    logic [4:0] off, b2, b3, b4, cnt_inc;
    logic [4:0] ix_da, ix_sp, ix_sa;

    assign dmode   = r_fc[mhp_pkg::FC_DST_MODE_LSB +: 2];
    assign smode   = r_fc[mhp_pkg::FC_SRC_MODE_LSB +: 2];
    assign intra   = r_fc[mhp_pkg::FC_INTRA_BIT];
    assign dpl     = (dmode != mhp_pkg::MODE_NONE) ? 5'd2 : 5'd0;
    assign dal     = mhp_pkg::addr_len(dmode);
    assign spl     = (smode != mhp_pkg::MODE_NONE && !intra) ? 5'd2 : 5'd0;
    assign sal     = mhp_pkg::addr_len(smode);
    assign b2      = dpl + dal;
    assign b3      = b2 + spl;
    assign b4      = b3 + sal;
    assign total   = mhp_pkg::HDR_FIXED + b4;
    assign off     = r_cnt - mhp_pkg::HDR_FIXED;
    assign cnt_inc = r_cnt + 5'd1;
    assign ix_da   = off - dpl;
    assign ix_sp   = off - b2;
    assign ix_sa   = off - b3;

    always_comb begin
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_fc       = r_fc;
        n_seq      = r_seq;
        n_dst_pan  = r_dst_pan;
        n_src_pan  = r_src_pan;
        n_dst_addr = r_dst_addr;
        n_src_addr = r_src_addr;
        n_ack_wait = r_ack_wait;
        n_exp_seq  = r_exp_seq;
        o_done     = 1'b0;
        if (i_step) begin
            if (i_item.frame_start) begin
                n_phase    = mhp_pkg::PH_HDR;
                n_fc       = {8'h00, i_item.rx_byte};
                n_cnt      = mhp_pkg::CNT_FC_HI;
                n_seq      = 8'h00;
                n_dst_pan  = mhp_pkg::PAN_NONE;
                n_src_pan  = mhp_pkg::PAN_NONE;
                n_dst_addr = 64'h0;
                n_src_addr = 64'h0;
                n_ack_wait = i_item.awaiting_ack;
                n_exp_seq  = i_item.last_tx_seq;
            end else if (r_phase == mhp_pkg::PH_HDR) begin
                if (r_cnt == mhp_pkg::CNT_FC_HI) begin
                    n_fc  = {i_item.rx_byte, r_fc[7:0]};
                    n_cnt = mhp_pkg::CNT_SEQ;
                end else begin
                    if (r_cnt == mhp_pkg::CNT_SEQ) begin
                        n_seq = i_item.rx_byte;
                    end else if (off < dpl) begin
                        n_dst_pan[{off[0], 3'b000} +: 8] = i_item.rx_byte;
                    end else if (off < b2) begin
                        n_dst_addr[{ix_da[2:0], 3'b000} +: 8] = i_item.rx_byte;
                    end else if (off < b3) begin
                        n_src_pan[{ix_sp[0], 3'b000} +: 8] = i_item.rx_byte;
                    end else if (off < b4) begin
                        n_src_addr[{ix_sa[2:0], 3'b000} +: 8] = i_item.rx_byte;
                    end
                    n_cnt = cnt_inc;
                    if (cnt_inc >= total) begin
                        // intra-pan: source pan follows the destination pan
                        if (smode != mhp_pkg::MODE_NONE && intra) begin
                            n_src_pan = n_dst_pan;
                        end
                        n_phase = mhp_pkg::PH_IDLE;
                        o_done  = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        o_result.frame_type   = r_fc[2:0];
        o_result.ack_mismatch = (r_fc[2:0] == mhp_pkg::TYPE_ACK) &&
                                (!r_ack_wait || n_seq != r_exp_seq);
        o_result.seq_num      = n_seq;
        o_result.ack_request  = r_fc[mhp_pkg::FC_ACK_REQ_BIT];
        o_result.dst_mode     = dmode;
        o_result.dst_pan      = n_dst_pan;
        o_result.dst_addr     = n_dst_addr;
        o_result.src_mode     = smode;
        o_result.src_pan      = n_src_pan;
        o_result.src_addr     = n_src_addr;
        o_result.header_len   = total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mhp_pkg::PH_IDLE;
            r_cnt   <= 5'd0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    // field registers are loaded on every frame start before use
    always_ff @(posedge i_clk) begin
        r_fc       <= n_fc;
        r_seq      <= n_seq;
        r_dst_pan  <= n_dst_pan;
        r_src_pan  <= n_src_pan;
        r_dst_addr <= n_dst_addr;
        r_src_addr <= n_src_addr;
        r_ack_wait <= n_ack_wait;
        r_exp_seq  <= n_exp_seq;
    end

endmodule

`default_nettype wire

[rtl/mac_header_parser.sv]
// IEEE 802.15.4 MAC header parser top level: input register, header core, result register
// depends on mhp_pkg, mhp_stream_if and mhp_hdr_core
`default_nettype none

// Takes one received byte per cycle on i_rx while o_hdr is not stalled and, on the
// byte that completes the MAC header, delivers one item on o_hdr with every header
// field. A byte is registered on entry and its effect on the header state is computed
// from the input register whenever the output can advance; a finished header is loaded
// into the result register, so o_hdr.valid rises once its last byte has passed the
// input and result registers. Bytes are taken back to back at one per cycle while o_hdr
// accepts its results, and while a result waits on o_hdr, i_rx.ready stays high only while
// the input register is empty.
module mac_header_parser (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    mhp_stream_if.sink        i_rx,
    mhp_stream_if.source      o_hdr
);

    logic                r_in_vld;
    mhp_pkg::t_rx_item   r_in;
    logic                r_out_vld;
    mhp_pkg::t_hdr_item  r_out;

    logic                advance;
    logic                done;
    mhp_pkg::t_hdr_item  result;

    assign advance     = !r_out_vld || o_hdr.ready;
    assign i_rx.ready  = !r_in_vld || advance;
    assign o_hdr.valid = r_out_vld;
    assign o_hdr.data  = r_out;

    mhp_hdr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (r_in_vld && advance),
        .i_item   (r_in),
        .o_done   (done),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_rx.ready) begin
                r_in_vld <= i_rx.valid;
            end
            if (advance) begin
                r_out_vld <= done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in <= i_rx.data;
        end
        if (done) begin
            r_out <= result;
        end
    end

endmodule

`default_nettype wire
